### rtl/assert_macros.svh
// Assertion helpers; both sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

### rtl/dpf_pkg.sv
package dpf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ENDPOINT_BITS = 48;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int D2_W    = 50;
  localparam int S_W     = 56;
  localparam int CLIP_W  = 24;
  localparam int CLIP2_W = 2 * CLIP_W;

  localparam logic [CLIP_W-1:0]  CLIP_RESET  = 24'd2560000;
  localparam logic [CLIP2_W-1:0] CLIP2_RESET = 48'd6553600000000;

  localparam logic [2:0] ADDR_CLIP = 3'd0;

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_FORWARD = 1'b1;

  localparam logic [2:0] PRIO_HIGHEST      = 3'd0;
  localparam logic [2:0] PRIO_ABOVE_NORMAL = 3'd1;
  localparam logic [2:0] PRIO_NORMAL       = 3'd2;
  localparam logic [2:0] PRIO_BELOW_NORMAL = 3'd3;
  localparam logic [2:0] PRIO_LOWEST       = 3'd4;

  typedef struct packed {
    logic                      op;
    logic [ENDPOINT_BITS-1:0]  key;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } item_t;

  typedef struct packed {
    logic [ENDPOINT_BITS-1:0] ep;
    logic [2:0]               prio;
    logic                     last;
  } res_t;

endpackage

### rtl/dpf_front.sv
module dpf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dpf_pkg::item_t item_i,
  output logic          full,
  output logic          item_valid,
  input  logic          item_ready,
  output dpf_pkg::item_t item_o
);

  dpf_pkg::item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item_o     = q_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = item_valid && item_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= item_i;
    end
  end

endmodule

### rtl/dpf_back.sv
`include "assert_macros.svh"

module dpf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  dpf_pkg::item_t                item_i,
  output logic                          item_ready,
  input  logic [dpf_pkg::CLIP2_W-1:0]   clip2,
  output logic                          res_empty,
  input  logic                          res_pop,
  output dpf_pkg::res_t                 res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_UPD   = 2'd1;
  localparam logic [1:0] ST_FWD   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam int N  = dpf_pkg::TABLE_ENTRIES;
  localparam int EW = dpf_pkg::ENDPOINT_BITS;
  localparam int CW = dpf_pkg::COORD_W;
  localparam int DW = dpf_pkg::DIFF_W;
  localparam int QW = dpf_pkg::D2_W;
  localparam int SW = dpf_pkg::S_W;

  // table
  logic [N-1:0]  valid_r;
  logic [EW-1:0] tbl_ep_r [N];
  logic [CW-1:0] tbl_x_r  [N];
  logic [CW-1:0] tbl_y_r  [N];
  logic [CW-1:0] tbl_z_r  [N];

  logic [1:0]                 state_r, state_nxt;
  logic [dpf_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [dpf_pkg::IDX_W-1:0]  ridx;
  dpf_pkg::item_t             cur_r;
  logic                       mfound_r, ffound_r;
  logic [dpf_pkg::IDX_W-1:0]  mslot_r, fslot_r;

  logic en, last_idx, hit, free_e, wr_en, issue_v, issue_end, take;
  logic [dpf_pkg::IDX_W-1:0] wslot;

  // pipeline
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_end_r, s2_end_r, s3_end_r, s4_end_r;
  logic [EW-1:0] s1_ep_r, s2_ep_r, s3_ep_r, s4_ep_r;
  logic [DW-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic [QW-1:0] s2_qx_r, s2_qy_r, s2_qz_r;
  logic [QW-1:0] s3_d2_r, s3_m2_r, max_r;
  logic [SW-1:0] s4_s_r, s4_m_r, s4_m9_r;

  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0] ax, ay, az;
  logic [QW-1:0] sum, mx, d2c;
  logic [2:0]    prio;

  // pending result and output queue
  logic          pend_v_r;
  logic [EW-1:0] pend_ep_r;
  logic [2:0]    pend_prio_r;
  logic          do_push, do_pop;
  dpf_pkg::res_t push_w;
  dpf_pkg::res_t oq_r [2];
  logic [1:0]    oq_cnt_r;
  logic          oq_wp_r, oq_rp_r;

  assign ridx       = idx_r[dpf_pkg::IDX_W-1:0];
  assign en         = (oq_cnt_r != 2'd2);
  assign item_ready = (state_r == ST_IDLE);
  assign take       = item_valid && item_ready;
  assign last_idx   = (idx_r == dpf_pkg::CNT_W'(N - 1));
  assign hit        = valid_r[ridx] && (tbl_ep_r[ridx] == cur_r.key);
  assign free_e     = !valid_r[ridx];

  // first match wins, else the lowest free slot, else drop
  always_comb begin
    wr_en = 1'b0;
    wslot = ridx;
    if (state_r == ST_UPD && last_idx) begin
      priority if (mfound_r) begin
        wr_en = 1'b1;
        wslot = mslot_r;
      end else if (hit) begin
        wr_en = 1'b1;
        wslot = ridx;
      end else if (ffound_r) begin
        wr_en = 1'b1;
        wslot = fslot_r;
      end else if (free_e) begin
        wr_en = 1'b1;
        wslot = ridx;
      end
    end
  end

  assign issue_end = (state_r == ST_FWD) && (idx_r == dpf_pkg::CNT_W'(N));
  assign issue_v   = (state_r == ST_FWD) && !issue_end && valid_r[ridx] &&
                     (tbl_ep_r[ridx] != cur_r.key);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          idx_nxt   = '0;
          state_nxt = (item_i.op == dpf_pkg::OP_FORWARD) ? ST_FWD : ST_UPD;
        end
      end
      ST_UPD: begin
        idx_nxt = idx_r + 1'b1;
        if (last_idx) state_nxt = ST_IDLE;
      end
      ST_FWD: begin
        if (en) begin
          idx_nxt = idx_r + 1'b1;
          if (issue_end) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (en && s4_end_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      mfound_r <= 1'b0;
      ffound_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (take) begin
        mfound_r <= 1'b0;
        ffound_r <= 1'b0;
      end else if (state_r == ST_UPD) begin
        if (hit && !mfound_r)    mfound_r <= 1'b1;
        if (free_e && !ffound_r) ffound_r <= 1'b1;
      end
      if (wr_en) valid_r[wslot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur_r <= item_i;
    if (state_r == ST_UPD) begin
      if (hit && !mfound_r)    mslot_r <= ridx;
      if (free_e && !ffound_r) fslot_r <= ridx;
    end
    if (wr_en) begin
      tbl_ep_r[wslot] <= cur_r.key;
      tbl_x_r[wslot]  <= cur_r.x;
      tbl_y_r[wslot]  <= cur_r.y;
      tbl_z_r[wslot]  <= cur_r.z;
    end
  end

  // stage 1: coordinate differences
  always_comb begin
    dx = $signed({cur_r.x[CW-1], cur_r.x}) - $signed({tbl_x_r[ridx][CW-1], tbl_x_r[ridx]});
    dy = $signed({cur_r.y[CW-1], cur_r.y}) - $signed({tbl_y_r[ridx][CW-1], tbl_y_r[ridx]});
    dz = $signed({cur_r.z[CW-1], cur_r.z}) - $signed({tbl_z_r[ridx][CW-1], tbl_z_r[ridx]});
    ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    az = dz[DW-1] ? DW'(-dz) : DW'(dz);
  end

  // stage 3: sum, running maximum and clip
  always_comb begin
    sum = s2_qx_r + s2_qy_r + s2_qz_r;
    mx  = (sum > max_r) ? sum : max_r;
    d2c = sum;
    if (mx > QW'(clip2)) begin
      mx  = QW'(clip2);
      d2c = QW'(clip2);
    end
  end

  // stage 5: bucket by squared ratio steps
  always_comb begin
    priority if (s4_m_r == '0)          prio = dpf_pkg::PRIO_HIGHEST;
    else if (s4_s_r < s4_m_r)           prio = dpf_pkg::PRIO_HIGHEST;
    else if (s4_s_r < (s4_m_r << 2))    prio = dpf_pkg::PRIO_ABOVE_NORMAL;
    else if (s4_s_r < s4_m9_r)          prio = dpf_pkg::PRIO_NORMAL;
    else if (s4_s_r < (s4_m_r << 4))    prio = dpf_pkg::PRIO_BELOW_NORMAL;
    else                                prio = dpf_pkg::PRIO_LOWEST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s1_end_r <= 1'b0; s2_end_r <= 1'b0; s3_end_r <= 1'b0; s4_end_r <= 1'b0;
      max_r    <= '0;
      pend_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= issue_v;  s1_end_r <= issue_end;
      s2_v_r <= s1_v_r;   s2_end_r <= s1_end_r;
      s3_v_r <= s2_v_r;   s3_end_r <= s2_end_r;
      s4_v_r <= s3_v_r;   s4_end_r <= s3_end_r;
      if (s2_v_r) max_r <= mx;
      if (s4_v_r) begin
        pend_v_r <= 1'b1;
      end else if (s4_end_r) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ep_r <= tbl_ep_r[ridx];
      s1_ax_r <= ax;
      s1_ay_r <= ay;
      s1_az_r <= az;
      s2_ep_r <= s1_ep_r;
      s2_qx_r <= QW'(s1_ax_r) * QW'(s1_ax_r);
      s2_qy_r <= QW'(s1_ay_r) * QW'(s1_ay_r);
      s2_qz_r <= QW'(s1_az_r) * QW'(s1_az_r);
      s3_ep_r <= s2_ep_r;
      s3_d2_r <= d2c;
      s3_m2_r <= mx;
      s4_ep_r <= s3_ep_r;
      s4_s_r  <= (SW'(s3_d2_r) << 4) + (SW'(s3_d2_r) << 3) + SW'(s3_d2_r);
      s4_m_r  <= SW'(s3_m2_r);
      s4_m9_r <= (SW'(s3_m2_r) << 3) + SW'(s3_m2_r);
      if (s4_v_r) begin
        pend_ep_r   <= s4_ep_r;
        pend_prio_r <= prio;
      end
    end
  end

  // hold one result back so the final word of a run can carry last
  assign do_push     = en && pend_v_r && (s4_v_r || s4_end_r);
  assign push_w.ep   = pend_ep_r;
  assign push_w.prio = pend_prio_r;
  assign push_w.last = s4_end_r;

  assign res_empty = (oq_cnt_r == 2'd0);
  assign res_o     = oq_r[oq_rp_r];
  assign do_pop    = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_cnt_r <= 2'd0;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
    end else begin
      if (do_push && !do_pop) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
      if (do_push) oq_wp_r <= ~oq_wp_r;
      if (do_pop)  oq_rp_r <= ~oq_rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) oq_r[oq_wp_r] <= push_w;
  end

  `ASSERT_CLK(a_oq_bound, oq_cnt_r <= 2'd2, "output queue overflow")
  `ASSERT_CLK(a_end_in_drain, s4_end_r |-> state_r == ST_DRAIN, "end word outside drain")
  `ASSERT_NEVER(a_idle_clean, state_r == ST_IDLE && (pend_v_r || s1_v_r || s2_v_r ||
                s3_v_r || s4_v_r), "pipeline busy while idle")

endmodule

### rtl/distance_priority_forwarder.sv
// Update item: walks every table entry in the back end; no result word.
// Forward item: one table entry per cycle, while the output queue has room, through
// a five-stage distance pipeline; the first word is pushed as the result of
// the second matching entry reaches the last stage, the last one after the walk drains.
// Items queue two deep at the input and results two deep at the output.
// Reset clears the table, the running maximum and clip_distance to 10000.0.
module distance_priority_forwarder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  in_operation,
  input  logic [dpf_pkg::ENDPOINT_BITS-1:0]     in_source_endpoint,
  input  logic signed [dpf_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [dpf_pkg::COORD_W-1:0]    in_pos_y,
  input  logic signed [dpf_pkg::COORD_W-1:0]    in_pos_z,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [dpf_pkg::ENDPOINT_BITS-1:0]     out_dest_endpoint,
  output logic [2:0]                            out_priority_res,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  dpf_pkg::item_t in_item, q_item;
  dpf_pkg::res_t  res;
  logic q_valid, q_ready;
  logic [dpf_pkg::CLIP_W-1:0]  clip_r;
  logic [dpf_pkg::CLIP2_W-1:0] clip2_r;

  assign in_item.op  = in_operation;
  assign in_item.key = in_source_endpoint;
  assign in_item.x   = in_pos_x;
  assign in_item.y   = in_pos_y;
  assign in_item.z   = in_pos_z;

  assign pready = 1'b1;
  assign prdata = (paddr == dpf_pkg::ADDR_CLIP) ? {8'd0, clip_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r  <= dpf_pkg::CLIP_RESET;
      clip2_r <= dpf_pkg::CLIP2_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == dpf_pkg::ADDR_CLIP) begin
        clip_r <= pwdata[dpf_pkg::CLIP_W-1:0];
      end
      clip2_r <= dpf_pkg::CLIP2_W'(clip_r) * dpf_pkg::CLIP2_W'(clip_r);
    end
  end

  dpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .item_i     (in_item),
    .full       (full),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item_o     (q_item)
  );

  dpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_i     (q_item),
    .item_ready (q_ready),
    .clip2      (clip2_r),
    .res_empty  (empty),
    .res_pop    (pop),
    .res_o      (res)
  );

  assign out_dest_endpoint = res.ep;
  assign out_priority_res  = res.prio;
  assign out_last          = res.last;

endmodule

### tb/distance_priority_forwarder_test.sv
`timescale 1ns / 1ps

module distance_priority_forwarder_test;

  localparam int NSLOT = dpf_pkg::TABLE_ENTRIES;
  localparam int EPW   = dpf_pkg::ENDPOINT_BITS;
  localparam int CRW   = dpf_pkg::COORD_W;

  typedef struct {
    logic [EPW-1:0] ep;
    logic [2:0]     prio;
    logic           last;
  } fwd_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_operation = dpf_pkg::OP_UPDATE;
  logic [EPW-1:0] in_source_endpoint = '0;
  logic signed [CRW-1:0] in_pos_x = '0;
  logic signed [CRW-1:0] in_pos_y = '0;
  logic signed [CRW-1:0] in_pos_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic [EPW-1:0] out_dest_endpoint;
  logic [2:0] out_priority_res;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  distance_priority_forwarder dut (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic                          tbl_valid [NSLOT];
  logic [EPW-1:0]                tbl_ep [NSLOT];
  logic signed [CRW-1:0]         tbl_x [NSLOT];
  logic signed [CRW-1:0]         tbl_y [NSLOT];
  logic signed [CRW-1:0]         tbl_z [NSLOT];
  logic [dpf_pkg::D2_W-1:0]      peak_d2;
  logic [dpf_pkg::CLIP_W-1:0]    clip_dist;

  fwd_word_t expected_words[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [EPW-1:0] known_eps[$];

  function automatic logic [2:0] rank_priority(logic [63:0] d2, logic [63:0] m2);
    logic [63:0] s;
    s = 25 * d2;
    if (m2 == 0) return dpf_pkg::PRIO_HIGHEST;
    if (s < m2) return dpf_pkg::PRIO_HIGHEST;
    if (s < 4 * m2) return dpf_pkg::PRIO_ABOVE_NORMAL;
    if (s < 9 * m2) return dpf_pkg::PRIO_NORMAL;
    if (s < 16 * m2) return dpf_pkg::PRIO_BELOW_NORMAL;
    return dpf_pkg::PRIO_LOWEST;
  endfunction

  function automatic logic [63:0] axis_sq(logic signed [CRW-1:0] a,
                                          logic signed [CRW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic void predict_item(logic op, logic [EPW-1:0] key,
                                       logic signed [CRW-1:0] x,
                                       logic signed [CRW-1:0] y,
                                       logic signed [CRW-1:0] z);
    int slot, free_slot, n;
    logic [63:0] d2, clip2, m;
    fwd_word_t w;
    slot = -1;
    free_slot = -1;
    n = 0;
    if (op == dpf_pkg::OP_UPDATE) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tbl_valid[i] && tbl_ep[i] == key) begin
          slot = i;
          break;
        end
        if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      end
      if (slot < 0) slot = free_slot;
      if (slot >= 0) begin
        tbl_valid[slot] = 1'b1;
        tbl_ep[slot] = key;
        tbl_x[slot] = x;
        tbl_y[slot] = y;
        tbl_z[slot] = z;
      end
      return;
    end
    clip2 = 64'(clip_dist) * 64'(clip_dist);
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_valid[i] || tbl_ep[i] == key) continue;
      d2 = axis_sq(x, tbl_x[i]) + axis_sq(y, tbl_y[i]) + axis_sq(z, tbl_z[i]);
      m = 64'(peak_d2);
      if (d2 > m) m = d2;
      if (m > clip2) begin
        m = clip2;
        d2 = clip2;
      end
      peak_d2 = m[dpf_pkg::D2_W-1:0];
      w.ep = tbl_ep[i];
      w.prio = rank_priority(d2, 64'(peak_d2));
      w.last = 1'b0;
      expected_words = {expected_words, w};
      n++;
    end
    if (n > 0) expected_words[$].last = 1'b1;
  endfunction

  // Called at a falling edge; returns at a falling edge with push still high,
  // so the caller either sends again or drops push through wait_idle.
  task automatic send_item(logic op, logic [EPW-1:0] key,
                           logic signed [CRW-1:0] x,
                           logic signed [CRW-1:0] y,
                           logic signed [CRW-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    in_source_endpoint <= key;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(op, key, x, y, z);
    @(negedge clk);
  endtask

  // Drop push, drain expected words, then let queued items without words finish.
  task automatic wait_idle();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4 * (NSLOT + 6)) @(negedge clk);
  endtask

  task automatic write_clip(logic [dpf_pkg::CLIP_W-1:0] value);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= dpf_pkg::ADDR_CLIP;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    clip_dist = value;
  endtask

  function automatic logic signed [CRW-1:0] rand_coord(int span);
    case ($urandom_range(3))
      0: return CRW'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return CRW'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic logic [EPW-1:0] pick_key();
    if (known_eps.size() == 0 || $urandom_range(9) < 2)
      return EPW'({$urandom, $urandom});
    return known_eps[$urandom_range(known_eps.size() - 1)];
  endfunction

  always @(negedge clk)
    pop <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    fwd_word_t w;
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: ep=%h prio=%0d last=%b",
                   out_dest_endpoint, out_priority_res, out_last);
      end else begin
        w = expected_words.pop_front();
        if (out_dest_endpoint !== w.ep || out_priority_res !== w.prio
            || out_last !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ep=%h prio=%0d last=%b got ep=%h prio=%0d last=%b",
                     w.ep, w.prio, w.last, out_dest_endpoint, out_priority_res,
                     out_last);
        end
      end
    end
  end

  task automatic test_directed();
    logic [EPW-1:0] a, b;
    a = '0;
    b = '1;
    // forward into an empty table, then lone entry skipped as source
    send_item(dpf_pkg::OP_FORWARD, a, 0, 0, 0);
    send_item(dpf_pkg::OP_UPDATE, a, 0, 0, 0);
    send_item(dpf_pkg::OP_FORWARD, a, 0, 0, 0);
    // zero distance with zero maximum
    send_item(dpf_pkg::OP_UPDATE, b, 0, 0, 0);
    send_item(dpf_pkg::OP_FORWARD, 48'h5, 0, 0, 0);
    // extreme coordinates, clipped maximum
    send_item(dpf_pkg::OP_UPDATE, b, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(dpf_pkg::OP_FORWARD, 48'h5, 24'sh800000, 24'sh800000, 24'sh800000);
    // fill the table, then one more new endpoint is dropped
    for (int i = 2; i < NSLOT + 1; i++)
      send_item(dpf_pkg::OP_UPDATE, 48'h100 + i, CRW'(i * 300), CRW'(-i * 50), 0);
    send_item(dpf_pkg::OP_FORWARD, a, 0, 0, 0);
    send_item(dpf_pkg::OP_UPDATE, a, 24'sh000100, 0, 0);
    send_item(dpf_pkg::OP_FORWARD, b, 0, 0, 0);
  endtask

  task automatic test_clip_settings();
    // lowered clip shrinks an older maximum; zero clip forces zero maximum
    write_clip('0);
    send_item(dpf_pkg::OP_FORWARD, 48'h7, 24'sh001000, 0, 0);
    write_clip(24'd1);
    send_item(dpf_pkg::OP_FORWARD, 48'h7, 24'sh000002, 0, 0);
    write_clip('1);
    send_item(dpf_pkg::OP_FORWARD, 48'h7, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    write_clip(24'd3000);
    send_item(dpf_pkg::OP_FORWARD, 48'h7, 24'sh000500, 24'sh000100, 0);
  endtask

  task automatic test_random_traffic(int count, int idle_s, int idle_r, int span);
    logic [EPW-1:0] k;
    send_idle_pct = idle_s;
    recv_stall_pct = idle_r;
    for (int i = 0; i < count; i++) begin
      k = pick_key();
      if ($urandom_range(1)) begin
        send_item(dpf_pkg::OP_UPDATE, k, rand_coord(span), rand_coord(span),
                  rand_coord(span));
        if (known_eps.size() < 24) known_eps = {known_eps, k};
      end else begin
        send_item(dpf_pkg::OP_FORWARD, k, rand_coord(span), rand_coord(span),
                  rand_coord(span));
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 50;
    send_item(dpf_pkg::OP_FORWARD, pick_key(), 0, 0, 0);
    wait_idle();
    send_item(dpf_pkg::OP_FORWARD, pick_key(), 24'sh000400, 0, 24'sh000200);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    peak_d2 = '0;
    clip_dist = dpf_pkg::CLIP_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_clip_settings();
    write_clip(dpf_pkg::CLIP_RESET);
    test_random_traffic(32, 0, 0, 4000);
    test_random_traffic(32, 73, 0, 4000);
    test_pause_until_drained();
    write_clip(24'd20000);
    test_random_traffic(32, 0, 73, 40000);
    test_random_traffic(32, 15, 15, 2000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dpf_pkg.sv
rtl/dpf_front.sv
rtl/dpf_back.sv
rtl/distance_priority_forwarder.sv
tb/distance_priority_forwarder_test.sv
